// File: rtl/cscan_request_scheduler_defines.svh
// assertion macros for the c-scan request scheduler checker
// no dependencies; included by files that carry concurrent assertions
`ifndef CSCAN_REQUEST_SCHEDULER_DEFINES_SVH
`define CSCAN_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define CSCAN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CSCAN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cscan_pkg.sv
// shared sizes, codes and types for the c-scan request scheduler
// no dependencies; imported by the scheduler core and its checker
package cscan_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int SECTOR_BITS = 48;
   localparam int TAG_BITS    = 8;

   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int PEND_BITS   = 6;
   localparam int SLOT_BITS   = 1 + TAG_BITS + SECTOR_BITS;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_WITHDRAW = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_NO_TAG = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_FIN  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic                   queue;
      logic [TAG_BITS-1:0]    tag;
      logic [SECTOR_BITS-1:0] sector;
   } slot_type;

endpackage

// File: rtl/cscan_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies; holds the scheduler's slot payloads
module cscan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cscan_request_scheduler.sv
// c-scan request scheduler: pending table in a slot ram, scan unit, result register
// depends on cscan_pkg and cscan_ram
//
// Use: the req channel carries one command per beat (add, dispatch, withdraw
// by tag). Every accepted beat yields exactly one rsp beat, in order, with the
// dispatched request (if any), a status code and the pending count after it.
// One command is worked on at a time; req_stall is high from acceptance until
// its result has moved into the rsp output register.
// Add, unused codes and a dispatch with nothing pending go straight from
// acceptance through S_DONE into the rsp register. A dispatch reads every
// slot of the slot ram, one per cycle through its single read port, then
// passes S_FIN and S_DONE. A withdraw stops at the first matching slot.
// The next command is taken the cycle after the result is registered.
// A stalled rsp beat holds in the output register; a finished result then
// waits in the block and req stays stalled until the rsp beat is taken.
// Reset (synchronous, active high) empties the table at once through the slot
// valid flops, zeroes both queue counts and the last served sector.
module cscan_request_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_operation,
   input  logic [cscan_pkg::SECTOR_BITS-1:0] req_sector,
   input  logic [cscan_pkg::TAG_BITS-1:0]    req_request_tag,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_dispatched,
   output logic [cscan_pkg::SECTOR_BITS-1:0] rsp_out_sector,
   output logic [cscan_pkg::TAG_BITS-1:0]    rsp_out_tag,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_all_empty,
   output logic [cscan_pkg::PEND_BITS-1:0]  rsp_pending_total
);
   import cscan_pkg::*;

   state_type               state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic                    cur_q_ff, cur_q_in;
   logic [SECTOR_BITS-1:0]  last_sector_ff, last_sector_in;
   logic [COUNT_BITS-1:0]   cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;

   logic [IDX_BITS:0]       rd_ptr_ff, rd_ptr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]     chk_idx_ff, chk_idx_in;
   logic                    found_ff, found_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [SECTOR_BITS-1:0]  best_sector_ff, best_sector_in;
   logic [TAG_BITS-1:0]     best_tag_ff, best_tag_in;
   logic                    best_q_ff, best_q_in;

   logic                    res_disp_ff, res_disp_in;
   logic [SECTOR_BITS-1:0]  res_sector_ff, res_sector_in;
   logic [TAG_BITS-1:0]     res_tag_ff, res_tag_in;
   logic [1:0]              res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_disp_ff, rsp_disp_in;
   logic [SECTOR_BITS-1:0]  rsp_sector_ff, rsp_sector_in;
   logic [TAG_BITS-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [PEND_BITS-1:0]    rsp_total_ff, rsp_total_in;

   logic                    free_any;
   logic [IDX_BITS-1:0]     free_idx;
   logic                    add_q;
   logic [COUNT_BITS-1:0]   cnt_cur, cnt_oth;
   logic [COUNT_BITS:0]     total_sum;
   logic                    hit;
   logic                    last_chk;

   logic                    ram_wr_en, ram_rd_en;
   logic [IDX_BITS-1:0]     ram_rd_addr;
   slot_type                ram_wr_slot, ram_rd_slot;
   logic [SLOT_BITS-1:0]    ram_rd_data;

   cscan_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx),
      .wr_data (ram_wr_slot),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_slot = slot_type'(ram_rd_data);
   assign ram_rd_addr = rd_ptr_ff[IDX_BITS-1:0];

   // lowest-numbered free slot
   always_comb begin
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   assign free_any  = ~&valid_ff;
   assign add_q     = (req_sector > last_sector_ff) ? cur_q_ff : ~cur_q_ff;
   assign cnt_cur   = cur_q_ff ? cnt1_ff : cnt0_ff;
   assign cnt_oth   = cur_q_ff ? cnt0_ff : cnt1_ff;
   assign total_sum = {1'b0, cnt0_ff} + {1'b0, cnt1_ff};
   assign ram_wr_slot = '{queue: add_q, tag: req_request_tag, sector: req_sector};

   // slot check on the beat of read data coming back from the ram
   always_comb begin
      if (op_ff == OP_DISPATCH) begin
         hit = valid_ff[chk_idx_ff] && (ram_rd_slot.queue == cur_q_ff) &&
               (!found_ff || (ram_rd_slot.sector < best_sector_ff));
      end else begin
         hit = valid_ff[chk_idx_ff] && (ram_rd_slot.tag == tag_ff) && !found_ff;
      end
   end

   assign last_chk = (chk_idx_ff == IDX_BITS'(TABLE_DEPTH - 1));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      tag_in         = tag_ff;
      valid_in       = valid_ff;
      cur_q_in       = cur_q_ff;
      last_sector_in = last_sector_ff;
      cnt0_in        = cnt0_ff;
      cnt1_in        = cnt1_ff;
      rd_ptr_in      = rd_ptr_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_sector_in = best_sector_ff;
      best_tag_in    = best_tag_ff;
      best_q_in      = best_q_ff;
      res_disp_in    = res_disp_ff;
      res_sector_in  = res_sector_ff;
      res_tag_in     = res_tag_ff;
      res_status_in  = res_status_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_disp_in    = rsp_disp_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_total_in   = rsp_total_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_operation;
               tag_in        = req_request_tag;
               rd_ptr_in     = '0;
               found_in      = 1'b0;
               res_disp_in   = 1'b0;
               res_sector_in = '0;
               res_tag_in    = '0;
               res_status_in = ST_OK;
               case (req_operation)
                  OP_ADD: begin
                     if (free_any) begin
                        ram_wr_en          = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        if (add_q) begin
                           cnt1_in = cnt1_ff + 1'b1;
                        end else begin
                           cnt0_in = cnt0_ff + 1'b1;
                        end
                     end else begin
                        res_status_in = ST_FULL;
                     end
                     state_in = S_DONE;
                  end
                  OP_DISPATCH: begin
                     // swap queue roles once the current sweep has drained
                     if (cnt_cur == '0 && cnt_oth != '0) begin
                        cur_q_in = ~cur_q_ff;
                     end
                     if (cnt_cur == '0 && cnt_oth == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_WITHDRAW: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_ptr_ff < (IDX_BITS + 1)'(TABLE_DEPTH)) begin
               ram_rd_en  = 1'b1;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_ptr_ff[IDX_BITS-1:0];
            end
            if (chk_vld_ff) begin
               if (hit) begin
                  found_in       = 1'b1;
                  best_idx_in    = chk_idx_ff;
                  best_sector_in = ram_rd_slot.sector;
                  best_tag_in    = ram_rd_slot.tag;
                  best_q_in      = ram_rd_slot.queue;
               end
               // a withdraw ends on its first match
               if (last_chk || (op_ff == OP_WITHDRAW && hit)) begin
                  state_in   = S_FIN;
                  chk_vld_in = 1'b0;
               end
            end
         end
         S_FIN: begin
            if (found_ff) begin
               valid_in[best_idx_ff] = 1'b0;
               if (best_q_ff) begin
                  cnt1_in = cnt1_ff - 1'b1;
               end else begin
                  cnt0_in = cnt0_ff - 1'b1;
               end
               if (op_ff == OP_DISPATCH) begin
                  res_disp_in    = 1'b1;
                  res_sector_in  = best_sector_ff;
                  res_tag_in     = best_tag_ff;
                  last_sector_in = best_sector_ff;
               end
            end else begin
               res_status_in = (op_ff == OP_DISPATCH) ? ST_EMPTY : ST_NO_TAG;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // counts already hold their after-step values here
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_disp_in   = res_disp_ff;
               rsp_sector_in = res_sector_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_status_in = res_status_ff;
               rsp_empty_in  = (total_sum == '0);
               rsp_total_in  = PEND_BITS'(total_sum);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         cur_q_ff       <= 1'b0;
         last_sector_ff <= '0;
         cnt0_ff        <= '0;
         cnt1_ff        <= '0;
         chk_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         cur_q_ff       <= cur_q_in;
         last_sector_ff <= last_sector_in;
         cnt0_ff        <= cnt0_in;
         cnt1_ff        <= cnt1_in;
         chk_vld_ff     <= chk_vld_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tag_ff         <= tag_in;
      rd_ptr_ff      <= rd_ptr_in;
      chk_idx_ff     <= chk_idx_in;
      best_idx_ff    <= best_idx_in;
      best_sector_ff <= best_sector_in;
      best_tag_ff    <= best_tag_in;
      best_q_ff      <= best_q_in;
      res_disp_ff    <= res_disp_in;
      res_sector_ff  <= res_sector_in;
      res_tag_ff     <= res_tag_in;
      res_status_ff  <= res_status_in;
      rsp_disp_ff    <= rsp_disp_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dispatched    = rsp_disp_ff;
   assign rsp_out_sector    = rsp_sector_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_all_empty     = rsp_empty_ff;
   assign rsp_pending_total = rsp_total_ff;

endmodule

// File: rtl/cscan_checker.sv
// port-level checks for the c-scan request scheduler, bound to the top level
// depends on cscan_pkg and cscan_request_scheduler_defines.svh
`include "cscan_request_scheduler_defines.svh"

module cscan_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_dispatched,
   input logic [cscan_pkg::SECTOR_BITS-1:0] rsp_out_sector,
   input logic [cscan_pkg::TAG_BITS-1:0]    rsp_out_tag,
   input logic [1:0]                       rsp_status,
   input logic                             rsp_all_empty,
   input logic [cscan_pkg::PEND_BITS-1:0]  rsp_pending_total
);
   import cscan_pkg::*;

   // a stalled rsp beat stays put
   `CSCAN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_sector) && $stable(rsp_out_tag) && $stable(rsp_status) && $stable(rsp_pending_total), "rsp beat changed while stalled")

   `CSCAN_ASSERT_IMP(a_empty_flag, clock, reset, rsp_valid, rsp_all_empty == (rsp_pending_total == '0), "all_empty disagrees with pending count")

   // a dispatch succeeds only with a clean status
   `CSCAN_ASSERT_IMP(a_disp_ok, clock, reset, rsp_valid && rsp_dispatched, rsp_status == ST_OK, "dispatch reported with error status")

   `CSCAN_ASSERT_IMP(a_idle_payload, clock, reset, rsp_valid && !rsp_dispatched, rsp_out_sector == '0 && rsp_out_tag == '0, "non-dispatch beat carries a request")

   // table full only when every slot is pending
   `CSCAN_ASSERT_IMP(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_pending_total == PEND_BITS'(TABLE_DEPTH), "table full reported below capacity")

endmodule

bind cscan_request_scheduler cscan_checker u_cscan_checker (.*);
